@@ design/wct_pkg.sv @@
package wct_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        RES_NEW    = 2'd0,
        RES_MERGED = 2'd1,
        RES_FULL   = 2'd2,
        RES_THRESH = 2'd3
    } res_status_t;

    // Datapath commands, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_RD_IDX,
        OP_IDX_INC,
        OP_MERGE,
        OP_INSERT,
        OP_OUT_LOAD,
        OP_PROD,
        OP_TOT_ACC,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_RND,
        OP_DIV_STEP,
        OP_DIV_REM,
        OP_WALK_INIT,
        OP_KEY_RD,
        OP_KEY_LATCH,
        OP_CUM_ACC,
        OP_THR_CHK,
        OP_FIX
    } dp_op_t;

    // Datapath status towards the controller
    typedef struct packed {
        logic idx_end;
        logic outer_end;
        logic match;
        logic tot_zero;
        logic cnt_zero;
        logic cut_zero;
        logic out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_CMP,
        ST_A_MERGE,
        ST_A_NEW,
        ST_F_RD,
        ST_F_PROD,
        ST_F_ACC,
        ST_F_MULI,
        ST_F_MUL,
        ST_F_RND,
        ST_F_DIV,
        ST_F_DIVR,
        ST_F_CHK,
        ST_T_KEY,
        ST_T_KEYW,
        ST_T_RD,
        ST_T_PROD,
        ST_T_ACC,
        ST_T_CHK,
        ST_T_FIX,
        ST_OUT
    } ctrl_state_t;

    localparam int          NUM_W        = 80;    // total_time * permille + rounding, 5 digits
    localparam logic [9:0]  PERMILLE_MAX = 10'd1000;
    localparam logic [9:0]  PERMILLE_RST = 10'd990;
    localparam logic [10:0] CUT_DIV      = 11'd1000;
    localparam logic [79:0] CUT_RND      = 80'd500;
    // ceil(2^36 / 1000): exact quotient by 1000 for any 26-bit digit step, taken from bit 36
    localparam logic [26:0] DIV_RECIP    = 27'd68719477;
    localparam logic [6:0]  MUL_LAST     = 7'd9;   // permille bits, MSB first
    localparam logic [6:0]  DIV_LAST     = 7'd4;   // 16-bit quotient digits, MSB first

endpackage

@@ design/weighted_count_threshold.sv @@
// Add beat: a search of the held entries for the key, then a merge into the matching entry,
// or an insert of a new entry (a full status when no free entry is left).
// Finish beat: totals pass, 10-step multiply, 5-digit divide, then one full table pass per
// candidate key; the multiply, divide and walk are skipped on a zero total.
// One beat at a time through the single-port entry table; the next beat is taken while
// the previous result waits in the output register.
// Reset (aresetn low, synchronous) empties the table and sets permille to 990.
module weighted_count_threshold
    import wct_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_exec_count,
    input  logic [19:0] s_time_weight,
    input  logic [19:0] s_size_weight,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_threshold_count,
    output logic [63:0] m_total_time,
    output logic [63:0] m_total_size,
    output logic [8:0]  m_entries_used
);

    dp_op_t     op;
    dp_status_t st;

    wct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .st       (st),
        .op       (op)
    );

    wct_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .op                (op),
        .st                (st),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_exec_count      (s_exec_count),
        .s_time_weight     (s_time_weight),
        .s_size_weight     (s_size_weight),
        .s_action          (s_action),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_status          (m_status),
        .m_threshold_count (m_threshold_count),
        .m_total_time      (m_total_time),
        .m_total_size      (m_total_size),
        .m_entries_used    (m_entries_used)
    );

endmodule

@@ design/wct_ctrl.sv @@
module wct_ctrl
    import wct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_action,
    output logic       s_ready,
    input  dp_status_t st,
    output dp_op_t     op
);

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence the datapath
    always_comb begin
        state_next = state_reg;
        op         = OP_NOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = OP_CAPTURE;
                    state_next = s_action ? ST_F_RD : ST_A_RD;
                end
            end
            // duplicate search
            ST_A_RD: begin
                if (st.idx_end) begin
                    state_next = ST_A_NEW;
                end else begin
                    op         = OP_RD_IDX;
                    state_next = ST_A_CMP;
                end
            end
            ST_A_CMP: begin
                if (st.match) begin
                    state_next = ST_A_MERGE;
                end else begin
                    op         = OP_IDX_INC;
                    state_next = ST_A_RD;
                end
            end
            ST_A_MERGE: begin
                op         = OP_MERGE;
                state_next = ST_OUT;
            end
            ST_A_NEW: begin
                op         = OP_INSERT;
                state_next = ST_OUT;
            end
            // totals pass
            ST_F_RD: begin
                if (st.idx_end) begin
                    state_next = ST_F_MULI;
                end else begin
                    op         = OP_RD_IDX;
                    state_next = ST_F_PROD;
                end
            end
            ST_F_PROD: begin
                op         = OP_PROD;
                state_next = ST_F_ACC;
            end
            ST_F_ACC: begin
                op         = OP_TOT_ACC;
                state_next = ST_F_RD;
            end
            // cutoff: shift-add multiply, round, digit-wise reciprocal divide
            ST_F_MULI: begin
                if (st.tot_zero) begin
                    state_next = ST_OUT;
                end else begin
                    op         = OP_MUL_INIT;
                    state_next = ST_F_MUL;
                end
            end
            ST_F_MUL: begin
                op = OP_MUL_STEP;
                if (st.cnt_zero) begin
                    state_next = ST_F_RND;
                end
            end
            ST_F_RND: begin
                op         = OP_RND;
                state_next = ST_F_DIV;
            end
            ST_F_DIV: begin
                op         = OP_DIV_STEP;
                state_next = ST_F_DIVR;
            end
            ST_F_DIVR: begin
                op = OP_DIV_REM;
                if (st.cnt_zero) begin
                    state_next = ST_F_CHK;
                end else begin
                    state_next = ST_F_DIV;
                end
            end
            ST_F_CHK: begin
                if (st.cut_zero) begin
                    state_next = ST_T_FIX;
                end else begin
                    op         = OP_WALK_INIT;
                    state_next = ST_T_KEY;
                end
            end
            // threshold walk: outer over candidates, inner over all entries
            ST_T_KEY: begin
                if (st.outer_end) begin
                    state_next = ST_T_FIX;
                end else begin
                    op         = OP_KEY_RD;
                    state_next = ST_T_KEYW;
                end
            end
            ST_T_KEYW: begin
                op         = OP_KEY_LATCH;
                state_next = ST_T_RD;
            end
            ST_T_RD: begin
                if (st.idx_end) begin
                    state_next = ST_T_CHK;
                end else begin
                    op         = OP_RD_IDX;
                    state_next = ST_T_PROD;
                end
            end
            ST_T_PROD: begin
                op         = OP_PROD;
                state_next = ST_T_ACC;
            end
            ST_T_ACC: begin
                op         = OP_CUM_ACC;
                state_next = ST_T_RD;
            end
            ST_T_CHK: begin
                op         = OP_THR_CHK;
                state_next = ST_T_KEY;
            end
            ST_T_FIX: begin
                op         = OP_FIX;
                state_next = ST_OUT;
            end
            // hand the result to the output register
            ST_OUT: begin
                if (st.out_free) begin
                    op         = OP_OUT_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/wct_dpath.sv @@
module wct_dpath
    import wct_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_op_t      op,
    output dp_status_t  st,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    input  logic [31:0] s_exec_count,
    input  logic [19:0] s_time_weight,
    input  logic [19:0] s_size_weight,
    input  logic        s_action,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [1:0]  m_status,
    output logic [31:0] m_threshold_count,
    output logic [63:0] m_total_time,
    output logic [63:0] m_total_size,
    output logic [8:0]  m_entries_used
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [19:0] b);
        logic [32:0] s;
        begin
            s = {1'b0, a} + {13'd0, b};
            return s[32] ? '1 : s[31:0];
        end
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        end
    endfunction

    // Entry table
    logic [31:0] key_mem  [TABLE_ENTRIES];
    logic [31:0] time_mem [TABLE_ENTRIES];
    logic [31:0] size_mem [TABLE_ENTRIES];

    // Control registers
    logic [CW-1:0] used_reg;
    logic          out_valid_reg;
    logic [9:0]    permille_reg;

    // Payload registers
    logic [31:0]   in_key_reg;
    logic [19:0]   in_time_reg;
    logic [19:0]   in_size_reg;
    logic [31:0]   rkey_reg, rtime_reg, rsize_reg;
    logic [CW-1:0] idx_reg, outer_reg;
    logic [63:0]   prod_reg;
    logic          ge_reg;
    logic [63:0]   tot_t_reg, tot_s_reg, cum_reg;
    logic [NUM_W-1:0] num_reg;
    logic [9:0]    rem_reg;
    logic [25:0]   dx_reg;
    logic [15:0]   dq_reg;
    logic [6:0]    cnt_reg;
    logic [31:0]   cur_key_reg, thr_reg;
    logic          found_reg;
    res_status_t   res_status_reg;
    res_status_t   m_status_reg;
    logic [31:0]   m_thr_reg;
    logic [63:0]   m_tot_t_reg, m_tot_s_reg;
    logic [8:0]    m_entries_reg;

    logic [9:0]    perm_eff;
    logic [25:0]   div_x;
    logic [52:0]   div_prod;
    logic [25:0]   div_sub;
    logic [AW-1:0] rd_addr;

    assign perm_eff = (permille_reg > PERMILLE_MAX) ? PERMILLE_MAX : permille_reg;
    assign rd_addr  = (op == OP_KEY_RD) ? outer_reg[AW-1:0] : idx_reg[AW-1:0];

    // One long-division digit: remainder and next 16 bits, quotient by reciprocal
    assign div_x    = {rem_reg, num_reg[NUM_W-1:NUM_W-16]};
    assign div_prod = div_x * DIV_RECIP;
    assign div_sub  = dx_reg - ({10'd0, dq_reg} * {15'd0, CUT_DIV});

    // Status to the controller
    always_comb begin
        st.idx_end   = (idx_reg == used_reg);
        st.outer_end = (outer_reg == used_reg);
        st.match     = (rkey_reg == in_key_reg);
        st.tot_zero  = (tot_t_reg == 64'd0);
        st.cnt_zero  = (cnt_reg == 7'd0);
        st.cut_zero  = (num_reg[63:0] == 64'd0);
        st.out_free  = !out_valid_reg || m_ready;
    end

    // Table read and write ports
    always_ff @(posedge aclk) begin
        if (op == OP_RD_IDX || op == OP_KEY_RD) begin
            rkey_reg  <= key_mem[rd_addr];
            rtime_reg <= time_mem[rd_addr];
            rsize_reg <= size_mem[rd_addr];
        end
        if (op == OP_MERGE) begin
            time_mem[idx_reg[AW-1:0]] <= sat_add32(rtime_reg, in_time_reg);
            size_mem[idx_reg[AW-1:0]] <= sat_add32(rsize_reg, in_size_reg);
        end else if (op == OP_INSERT && used_reg != FULL_CNT) begin
            key_mem[used_reg[AW-1:0]]  <= in_key_reg;
            time_mem[used_reg[AW-1:0]] <= {12'd0, in_time_reg};
            size_mem[used_reg[AW-1:0]] <= {12'd0, in_size_reg};
        end
    end

    // Fill count, output valid, configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            permille_reg  <= PERMILLE_RST;
        end else begin
            if (cfg_wr_en) begin
                permille_reg <= cfg_wr_data;
            end
            if (op == OP_INSERT && used_reg != FULL_CNT) begin
                used_reg <= used_reg + 1'b1;
            end else if (op == OP_OUT_LOAD && res_status_reg == RES_THRESH) begin
                used_reg <= '0;
            end
            if (op == OP_OUT_LOAD) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (op)
            OP_CAPTURE: begin
                in_key_reg     <= s_exec_count;
                in_time_reg    <= s_time_weight;
                in_size_reg    <= s_size_weight;
                idx_reg        <= '0;
                tot_t_reg      <= '0;
                tot_s_reg      <= '0;
                thr_reg        <= '0;
                found_reg      <= 1'b0;
                num_reg        <= '0;
                res_status_reg <= s_action ? RES_THRESH : RES_NEW;
            end
            OP_IDX_INC: begin
                idx_reg <= idx_reg + 1'b1;
            end
            OP_MERGE: begin
                res_status_reg <= RES_MERGED;
            end
            OP_INSERT: begin
                res_status_reg <= (used_reg == FULL_CNT) ? RES_FULL : RES_NEW;
            end
            OP_PROD: begin
                prod_reg <= rkey_reg * rtime_reg;
                ge_reg   <= (rkey_reg >= cur_key_reg);
            end
            OP_TOT_ACC: begin
                tot_t_reg <= sat_add64(tot_t_reg, prod_reg);
                tot_s_reg <= sat_add64(tot_s_reg, {32'd0, rsize_reg});
                idx_reg   <= idx_reg + 1'b1;
            end
            OP_MUL_INIT: begin
                num_reg <= '0;
                cnt_reg <= MUL_LAST;
            end
            OP_MUL_STEP: begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0}
                         + (perm_eff[cnt_reg[3:0]] ? {16'd0, tot_t_reg} : '0);
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_RND: begin
                num_reg <= num_reg + CUT_RND;
                rem_reg <= '0;
                cnt_reg <= DIV_LAST;
            end
            // take the top digit and estimate its quotient
            OP_DIV_STEP: begin
                dx_reg  <= div_x;
                dq_reg  <= div_prod[51:36];
                num_reg <= {num_reg[NUM_W-17:0], 16'd0};
            end
            // keep the remainder and shift the quotient digit in
            OP_DIV_REM: begin
                rem_reg       <= div_sub[9:0];
                num_reg[15:0] <= dq_reg;
                cnt_reg       <= cnt_reg - 1'b1;
            end
            OP_WALK_INIT: begin
                outer_reg <= '0;
                found_reg <= 1'b0;
            end
            OP_KEY_LATCH: begin
                cur_key_reg <= rkey_reg;
                cum_reg     <= '0;
                idx_reg     <= '0;
            end
            OP_CUM_ACC: begin
                if (ge_reg) begin
                    cum_reg <= sat_add64(cum_reg, prod_reg);
                end
                idx_reg <= idx_reg + 1'b1;
            end
            OP_THR_CHK: begin
                if (cum_reg >= num_reg[63:0] && (!found_reg || cur_key_reg > thr_reg)) begin
                    thr_reg   <= cur_key_reg;
                    found_reg <= 1'b1;
                end
                outer_reg <= outer_reg + 1'b1;
            end
            OP_FIX: begin
                if (thr_reg == 32'd0) begin
                    thr_reg <= 32'd1;
                end
            end
            OP_OUT_LOAD: begin
                m_status_reg  <= res_status_reg;
                m_entries_reg <= 9'(used_reg);
                if (res_status_reg == RES_THRESH) begin
                    m_thr_reg   <= thr_reg;
                    m_tot_t_reg <= tot_t_reg;
                    m_tot_s_reg <= tot_s_reg;
                end else begin
                    m_thr_reg   <= '0;
                    m_tot_t_reg <= '0;
                    m_tot_s_reg <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = m_status_reg;
    assign m_threshold_count = m_thr_reg;
    assign m_total_time      = m_tot_t_reg;
    assign m_total_size      = m_tot_s_reg;
    assign m_entries_used    = m_entries_reg;

    // Fill count never passes the table size
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= FULL_CNT)
        else $error("fill count beyond table size");

    // A finish result empties the table
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_OUT_LOAD && res_status_reg == RES_THRESH) |=> used_reg == '0)
        else $error("table not cleared after finish");

    // A new entry grows the fill count by one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_INSERT && used_reg != FULL_CNT) |=> used_reg == $past(used_reg) + 1'b1)
        else $error("insert did not grow the table");

    // Add results carry no totals
    a_add_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != RES_THRESH) |->
            (m_threshold_count == 32'd0 && m_total_time == 64'd0))
        else $error("add result carries totals");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import wct_pkg::*;

    localparam int NUM_SLOTS = 256;

    typedef struct {
        res_status_t status;
        logic [31:0] thr;
        logic [63:0] tot_time;
        logic [63:0] tot_size;
        logic [8:0]  used;
    } hist_result_t;

    // Histogram predictor and store of expected results
    class hist_scoreboard;
        logic [31:0]  key_tab [NUM_SLOTS];
        logic [31:0]  time_tab [NUM_SLOTS];
        logic [31:0]  size_tab [NUM_SLOTS];
        int           used_cnt;
        logic [9:0]   permille;
        hist_result_t due_q [$];
        int           mismatches;
        int           results_seen;
        int           finishes_seen;
        int           full_seen;

        function new();
            used_cnt    = 0;
            permille    = PERMILLE_RST;
            mismatches  = 0;
            results_seen = 0;
            finishes_seen = 0;
            full_seen   = 0;
        endfunction

        function logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
            logic [32:0] x;
            x = {1'b0, a} + {1'b0, b};
            return x[32] ? 32'hFFFF_FFFF : x[31:0];
        endfunction

        function logic [63:0] sat64(logic [63:0] a, logic [63:0] b);
            logic [64:0] x;
            x = {1'b0, a} + {1'b0, b};
            return x[64] ? 64'hFFFF_FFFF_FFFF_FFFF : x[63:0];
        endfunction

        function logic [63:0] weight(int i);
            return {32'd0, key_tab[i]} * {32'd0, time_tab[i]};
        endfunction

        // Work out the result of one accepted beat and queue it
        function void note_input(logic act, logic [31:0] key, logic [19:0] t, logic [19:0] s);
            hist_result_t r;
            int i;
            int hit;
            logic [63:0] p;
            logic [63:0] cut;
            logic [63:0] cum;
            logic found;
            r.thr = '0;
            r.tot_time = '0;
            r.tot_size = '0;
            if (act == 1'b0) begin
                hit = -1;
                for (i = 0; i < used_cnt; i++)
                    if (hit < 0 && key_tab[i] == key) hit = i;
                if (hit >= 0) begin
                    time_tab[hit] = sat32(time_tab[hit], {12'd0, t});
                    size_tab[hit] = sat32(size_tab[hit], {12'd0, s});
                    r.status = RES_MERGED;
                end else if (used_cnt < NUM_SLOTS) begin
                    key_tab[used_cnt]  = key;
                    time_tab[used_cnt] = {12'd0, t};
                    size_tab[used_cnt] = {12'd0, s};
                    used_cnt++;
                    r.status = RES_NEW;
                end else begin
                    r.status = RES_FULL;
                end
                r.used = used_cnt[8:0];
            end else begin
                for (i = 0; i < used_cnt; i++) begin
                    r.tot_time = sat64(r.tot_time, weight(i));
                    r.tot_size = sat64(r.tot_size, {32'd0, size_tab[i]});
                end
                if (r.tot_time != 0) begin
                    p = (permille > PERMILLE_MAX) ? 64'd1000 : {54'd0, permille};
                    cut = (r.tot_time / 1000) * p + ((r.tot_time % 1000) * p + 500) / 1000;
                    found = 1'b0;
                    // Largest key whose entries at or above it reach the cutoff
                    if (cut != 0) begin
                        for (i = 0; i < used_cnt; i++) begin
                            cum = '0;
                            for (int j = 0; j < used_cnt; j++)
                                if (key_tab[j] >= key_tab[i]) cum = sat64(cum, weight(j));
                            if (cum >= cut && (!found || key_tab[i] > r.thr)) begin
                                r.thr = key_tab[i];
                                found = 1'b1;
                            end
                        end
                    end
                    if (r.thr == 0) r.thr = 32'd1;
                end
                r.status = RES_THRESH;
                r.used = used_cnt[8:0];
                used_cnt = 0;
            end
            due_q.push_back(r);
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_result(logic [1:0] st, logic [31:0] thr, logic [63:0] tt,
                                   logic [63:0] ts, logic [8:0] used);
            hist_result_t e;
            results_seen++;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
                return;
            end
            e = due_q.pop_front();
            if (st == RES_THRESH) finishes_seen++;
            if (st == RES_FULL) full_seen++;
            if (st !== e.status || thr !== e.thr || tt !== e.tot_time ||
                ts !== e.tot_size || used !== e.used) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: exp st=%0d thr=%0d tt=%0d ts=%0d used=%0d",
                             e.status, e.thr, e.tot_time, e.tot_size, e.used);
                    $display("       got st=%0d thr=%0d tt=%0d ts=%0d used=%0d",
                             st, thr, tt, ts, used);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [9:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic [31:0] s_exec_count;
    logic [19:0] s_time_weight;
    logic [19:0] s_size_weight;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_threshold_count;
    logic [63:0] m_total_time;
    logic [63:0] m_total_size;
    logic [8:0]  m_entries_used;

    hist_scoreboard sb = new();
    bit  calm = 1'b0;
    int  hold_left = 0;
    int  beats_sent = 0;

    weighted_count_threshold #(.TABLE_ENTRIES(NUM_SLOTS)) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_exec_count      (s_exec_count),
        .s_time_weight     (s_time_weight),
        .s_size_weight     (s_size_weight),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_threshold_count (m_threshold_count),
        .m_total_time      (m_total_time),
        .m_total_size      (m_total_size),
        .m_entries_used    (m_entries_used)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Check result beats and pick the next ready, holding off on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_threshold_count, m_total_time, m_total_size,
                            m_entries_used);
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 30);
        end
    end

    // Offer one beat, idling now and then, and wait for its acceptance
    task automatic send_beat(logic act, logic [31:0] key, logic [19:0] t, logic [19:0] s);
        if (!calm && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_exec_count  <= key;
        s_time_weight <= t;
        s_size_weight <= s;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(act, key, t, s);
        beats_sent++;
    endtask

    task automatic add(logic [31:0] key, logic [19:0] t, logic [19:0] s);
        send_beat(1'b0, key, t, s);
    endtask

    task automatic finish_set();
        send_beat(1'b1, $urandom, 20'($urandom), 20'($urandom));
    endtask

    // Drain every expected result, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_permille(logic [9:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.permille = v;
    endtask

    initial begin
        int n;
        int m;
        logic [31:0] pool [16];
        s_valid       <= 1'b0;
        s_action      <= 1'b0;
        s_exec_count  <= '0;
        s_time_weight <= '0;
        s_size_weight <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        m_ready       <= 1'b0;
        aresetn       <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty finish, extremes, zero totals, permille corners
        finish_set();
        add(32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF);
        add(32'd0, 20'hFFFFF, 20'h00000);
        add(32'hFFFF_FFFF, 20'd1, 20'd1);
        add(32'd1, 20'd0, 20'hFFFFF);
        finish_set();
        add(32'd0, 20'd500, 20'd3);
        add(32'd7, 20'd0, 20'd9);
        finish_set();
        write_permille(10'd0);
        add(32'd5, 20'd100, 20'd1);
        add(32'd9, 20'd100, 20'd1);
        finish_set();
        write_permille(10'd1023);
        add(32'd5, 20'd100, 20'd1);
        add(32'd2, 20'd1, 20'd1);
        add(32'd9, 20'd100, 20'd1);
        finish_set();
        write_permille(10'd1000);
        add(32'd3, 20'd1, 20'd1);
        add(32'd4, 20'd1, 20'd1);
        finish_set();
        write_permille(10'd1);
        add(32'd3, 20'd1, 20'd1);
        add(32'h8000_0000, 20'hFFFFF, 20'd1);
        finish_set();

        // Build large entry sums and weighted totals
        write_permille(10'd990);
        calm = 1'b1;
        for (int i = 0; i < 300; i++) begin
            add(32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF);
            add(32'hFFFF_FFFE, 20'hFFFFF, 20'hFFFFF);
        end
        finish_set();
        calm = 1'b0;

        // Fill the table, overflow it, merge into it, then finish
        write_permille(10'd500);
        for (int i = 0; i < NUM_SLOTS; i++)
            add(32'd1000 + i * 7, 20'($urandom_range(0, 1000)), 20'($urandom));
        add(32'd3, 20'd1, 20'd1);
        add(32'd1000, 20'd5, 20'd5);
        finish_set();

        // Receiver holds off while the sender keeps offering
        drain();
        hold_left <= 3000;
        for (int i = 0; i < 6; i++)
            add($urandom_range(0, 3), 20'($urandom), 20'($urandom));
        finish_set();

        // Random sets of adds closed by a finish
        while (beats_sent < 1950) begin
            if ($urandom_range(99) < 15) begin
                case ($urandom_range(4))
                    0: write_permille(10'd0);
                    1: write_permille(10'd1000);
                    2: write_permille(10'd1023);
                    3: write_permille(10'd990);
                    default: write_permille(10'($urandom));
                endcase
            end
            if (beats_sent > 1300 && beats_sent < 1600) calm = 1'b1;
            else calm = 1'b0;
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(3))
                    0: pool[i] = $urandom;
                    1: pool[i] = $urandom_range(0, 20);
                    default: pool[i] = $urandom_range(0, 100000);
                endcase
            end
            m = $urandom_range(0, 3 * n);
            for (int i = 0; i < m; i++) begin
                if ($urandom_range(99) < 10)
                    add($urandom, 20'($urandom), 20'($urandom));
                else if ($urandom_range(99) < 20)
                    add(pool[$urandom_range(0, n - 1)], 20'hFFFFF, 20'hFFFFF);
                else
                    add(pool[$urandom_range(0, n - 1)], 20'($urandom), 20'($urandom));
            end
            finish_set();
            // Now and then the sender pauses until every result is back
            if ($urandom_range(99) < 5) drain();
        end
        calm = 1'b0;

        drain();
        repeat (100) @(posedge aclk);
        $display("Run covered %0d beats, %0d finishes, %0d table-full drops.",
                 beats_sent, sb.finishes_seen, sb.full_seen);
        $display("Permille corners, large totals, a full table and a long receiver stall were included.");
        if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
